[rtl/peak_valley_midpoint_threshold_top_macros.svh]
// Assertion helpers for the file that checks this block.
`ifndef PEAK_VALLEY_MIDPOINT_THRESHOLD_TOP_MACROS_SVH
`define PEAK_VALLEY_MIDPOINT_THRESHOLD_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define PVMT_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PVMT_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pvmt_pkg.sv]
package pvmt_pkg;

  localparam int SAMPLE_BITS = 11;
  localparam int COUNT_BITS  = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_PEAKS   = 2'd1;
  localparam logic [1:0] STATUS_NO_VALLEYS = 2'd2;

endpackage

[rtl/pvmt_front.sv]
module pvmt_front
  import pvmt_pkg::*;
#(
  parameter int SB = SAMPLE_BITS,
  parameter int CB = COUNT_BITS,
  localparam int TW = SB + CB,
  localparam int JW = 2 * TW + 2 * CB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [SB-1:0] in_sample,
  input  logic          in_pass_start,
  input  logic          in_run_end,
  input  logic          q_full,
  output logic          q_push,
  output logic [JW-1:0] q_data
);

  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  logic [SB-1:0] smoothed_r, smoothed_nxt;
  logic [SB-1:0] cand_val_r, cand_val_nxt;
  logic [SB-1:0] cand_before_r, cand_before_nxt;
  logic          cand_valid_r, cand_valid_nxt;
  logic [TW-1:0] ptotal_r, ptotal_nxt, vtotal_r, vtotal_nxt;
  logic [CB-1:0] ptally_r, ptally_nxt, vtally_r, vtally_nxt;

  logic          accept;
  logic [SB-1:0] hist;
  logic          cand_ok;
  logic [SB:0]   sum;
  logic [SB-1:0] smooth;
  logic          is_peak, is_valley;
  logic [TW-1:0] ptotal_upd, vtotal_upd;
  logic [CB-1:0] ptally_upd, vtally_upd;

  // The queue only fills when two run results wait behind the divider.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    hist    = in_pass_start ? '0 : smoothed_r;
    cand_ok = cand_valid_r && !in_pass_start;
    sum     = {1'b0, in_sample} + {1'b0, hist};
    smooth  = sum[SB:1];

    is_peak   = cand_ok && (cand_val_r > cand_before_r) && (cand_val_r > smooth) &&
                (ptally_r != CMAX);
    is_valley = cand_ok && (cand_val_r < cand_before_r) && (cand_val_r < smooth) &&
                (vtally_r != CMAX);

    ptotal_upd = is_peak   ? ptotal_r + TW'(cand_val_r) : ptotal_r;
    ptally_upd = is_peak   ? ptally_r + 1'b1 : ptally_r;
    vtotal_upd = is_valley ? vtotal_r + TW'(cand_val_r) : vtotal_r;
    vtally_upd = is_valley ? vtally_r + 1'b1 : vtally_r;

    smoothed_nxt    = smoothed_r;
    cand_val_nxt    = cand_val_r;
    cand_before_nxt = cand_before_r;
    cand_valid_nxt  = cand_valid_r;
    ptotal_nxt      = ptotal_r;
    vtotal_nxt      = vtotal_r;
    ptally_nxt      = ptally_r;
    vtally_nxt      = vtally_r;

    if (accept) begin
      if (in_run_end) begin
        // The run result leaves through the queue and the next run starts clean.
        smoothed_nxt    = '0;
        cand_val_nxt    = '0;
        cand_before_nxt = '0;
        cand_valid_nxt  = 1'b0;
        ptotal_nxt      = '0;
        vtotal_nxt      = '0;
        ptally_nxt      = '0;
        vtally_nxt      = '0;
      end else begin
        smoothed_nxt    = smooth;
        cand_val_nxt    = smooth;
        cand_before_nxt = hist;
        cand_valid_nxt  = 1'b1;
        ptotal_nxt      = ptotal_upd;
        vtotal_nxt      = vtotal_upd;
        ptally_nxt      = ptally_upd;
        vtally_nxt      = vtally_upd;
      end
    end
  end

  assign q_push = accept && in_run_end;
  assign q_data = {ptotal_upd, vtotal_upd, ptally_upd, vtally_upd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r    <= '0;
      cand_val_r    <= '0;
      cand_before_r <= '0;
      cand_valid_r  <= 1'b0;
      ptotal_r      <= '0;
      vtotal_r      <= '0;
      ptally_r      <= '0;
      vtally_r      <= '0;
    end else begin
      smoothed_r    <= smoothed_nxt;
      cand_val_r    <= cand_val_nxt;
      cand_before_r <= cand_before_nxt;
      cand_valid_r  <= cand_valid_nxt;
      ptotal_r      <= ptotal_nxt;
      vtotal_r      <= vtotal_nxt;
      ptally_r      <= ptally_nxt;
      vtally_r      <= vtally_nxt;
    end
  end

endmodule

[rtl/pvmt_queue.sv]
module pvmt_queue
  import pvmt_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == NW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = store_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/pvmt_back.sv]
module pvmt_back
  import pvmt_pkg::*;
#(
  parameter int SB = SAMPLE_BITS,
  parameter int CB = COUNT_BITS,
  localparam int TW = SB + CB,
  localparam int JW = 2 * TW + 2 * CB,
  localparam int CW = $clog2(TW)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [JW-1:0] q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [SB-1:0] out_threshold,
  output logic [1:0]    out_status,
  output logic [CB-1:0] out_peaks_found,
  output logic [CB-1:0] out_valleys_found
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] pdiv_r, pdiv_nxt, vdiv_r, vdiv_nxt;
  logic [CB-1:0] prem_r, prem_nxt, vrem_r, vrem_nxt;
  logic [CB-1:0] pden_r, pden_nxt, vden_r, vden_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [SB-1:0] thr_r, thr_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [CB-1:0] pcnt_r, pcnt_nxt, vcnt_r, vcnt_nxt;

  logic [CB:0]   ptrial, vtrial;
  logic          pfit, vfit;
  logic [SB:0]   mid_sum;
  logic [1:0]    fin_status;
  logic          load_out;

  // One restoring step per cycle on both quotients.
  always_comb begin
    ptrial = {prem_r, pdiv_r[TW-1]};
    vtrial = {vrem_r, vdiv_r[TW-1]};
    pfit   = (ptrial >= {1'b0, pden_r});
    vfit   = (vtrial >= {1'b0, vden_r});
  end

  always_comb begin
    fin_status = STATUS_OK;
    if (pden_r == '0) begin
      fin_status = fin_status | STATUS_NO_PEAKS;
    end
    if (vden_r == '0) begin
      fin_status = fin_status | STATUS_NO_VALLEYS;
    end
    mid_sum = {1'b0, pdiv_r[SB-1:0]} + {1'b0, vdiv_r[SB-1:0]};
  end

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pdiv_nxt      = pdiv_r;
    vdiv_nxt      = vdiv_r;
    prem_nxt      = prem_r;
    vrem_nxt      = vrem_r;
    pden_nxt      = pden_r;
    vden_nxt      = vden_r;
    out_valid_nxt = out_valid_r && out_stall;
    thr_nxt       = thr_r;
    status_nxt    = status_r;
    pcnt_nxt      = pcnt_r;
    vcnt_nxt      = vcnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pdiv_nxt  = q_data[JW-1 -: TW];
          vdiv_nxt  = q_data[JW-TW-1 -: TW];
          pden_nxt  = q_data[2*CB-1 -: CB];
          vden_nxt  = q_data[CB-1:0];
          prem_nxt  = '0;
          vrem_nxt  = '0;
          cnt_nxt   = CW'(TW - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        pdiv_nxt = {pdiv_r[TW-2:0], pfit};
        vdiv_nxt = {vdiv_r[TW-2:0], vfit};
        prem_nxt = pfit ? CB'(ptrial - {1'b0, pden_r}) : ptrial[CB-1:0];
        vrem_nxt = vfit ? CB'(vtrial - {1'b0, vden_r}) : vtrial[CB-1:0];
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          status_nxt    = fin_status;
          // A missing kind leaves a meaningless quotient, so the threshold is forced to zero.
          thr_nxt       = (fin_status == STATUS_OK) ? mid_sum[SB:1] : '0;
          pcnt_nxt      = pden_r;
          vcnt_nxt      = vden_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pdiv_r      <= pdiv_nxt;
      vdiv_r      <= vdiv_nxt;
      prem_r      <= prem_nxt;
      vrem_r      <= vrem_nxt;
      pden_r      <= pden_nxt;
      vden_r      <= vden_nxt;
      thr_r       <= thr_nxt;
      status_r    <= status_nxt;
      pcnt_r      <= pcnt_nxt;
      vcnt_r      <= vcnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_threshold     = thr_r;
  assign out_status        = status_r;
  assign out_peaks_found   = pcnt_r;
  assign out_valleys_found = vcnt_r;

endmodule

[rtl/peak_valley_midpoint_threshold_top.sv]
// Throughput: one sample beat per cycle while in_stall is low; a run-end beat hands its sums to a two-entry queue.
// A run-end beat's sums pass from the queue through ST_IDLE, the ST_DIV steps of the one-bit-per-cycle
// restoring dividers and ST_FIN into the output registers; the back end takes a new result only in ST_IDLE.
// Input stalls only while the queue holds two results waiting behind the divider.
// Reset (synchronous, rst_n low) clears history, accumulators, queue and output valid.
`include "peak_valley_midpoint_threshold_top_macros.svh"

module peak_valley_midpoint_threshold_top
  import pvmt_pkg::*;
#(
  parameter int SB          = SAMPLE_BITS,
  parameter int CB          = COUNT_BITS,
  parameter int QDEPTH      = QUEUE_DEPTH,
  localparam int JW         = 2 * (SB + CB) + 2 * CB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [SB-1:0] in_sample,
  input  logic          in_pass_start,
  input  logic          in_run_end,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [SB-1:0] out_threshold,
  output logic [1:0]    out_status,
  output logic [CB-1:0] out_peaks_found,
  output logic [CB-1:0] out_valleys_found
);

  logic          q_full, q_push, q_pop, q_valid;
  logic [JW-1:0] q_wdata, q_rdata;

  pvmt_front #(
    .SB(SB),
    .CB(CB)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_pass_start(in_pass_start),
    .in_run_end   (in_run_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  pvmt_queue #(
    .W    (JW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_rdata)
  );

  pvmt_back #(
    .SB(SB),
    .CB(CB)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_threshold    (out_threshold),
    .out_status       (out_status),
    .out_peaks_found  (out_peaks_found),
    .out_valleys_found(out_valleys_found)
  );

  `PVMT_ASSERT_ON(a_push_not_full, q_push |-> !q_full, "run result pushed into a full queue")
  `PVMT_ASSERT_ON(a_status_thr, out_valid && (out_status != STATUS_OK) |-> out_threshold == '0, "threshold nonzero with bad status")
  `PVMT_ASSERT_ON(a_no_peaks, out_valid && out_status[0] |-> out_peaks_found == '0, "no-peak status with peaks counted")
  `PVMT_ASSERT_ON(a_no_valleys, out_valid && out_status[1] |-> out_valleys_found == '0, "no-valley status with valleys counted")
  `PVMT_ASSERT_ALL(a_reset_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule

[tb/pvmt_threshold_checker.sv]
`timescale 1ns / 1ps

module pvmt_threshold_checker
  import pvmt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                  in_pass_start,
  input  logic                  in_run_end,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SAMPLE_BITS-1:0] out_threshold,
  input  logic [1:0]            out_status,
  input  logic [COUNT_BITS-1:0] out_peaks_found,
  input  logic [COUNT_BITS-1:0] out_valleys_found,
  output int                    mismatch_count,
  output int                    results_pending
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] threshold;
    logic [1:0]             status;
    logic [COUNT_BITS-1:0]  peaks;
    logic [COUNT_BITS-1:0]  valleys;
  } threshold_result_t;

  logic [SAMPLE_BITS-1:0] smooth_hist;
  logic [SAMPLE_BITS-1:0] cand_value;
  logic [SAMPLE_BITS-1:0] cand_left;
  logic                   cand_pending;
  logic [SUM_BITS-1:0]    peak_sum;
  logic [SUM_BITS-1:0]    valley_sum;
  logic [COUNT_BITS-1:0]  peak_cnt;
  logic [COUNT_BITS-1:0]  valley_cnt;
  threshold_result_t      expected_thresholds[$];

  initial begin
    mismatch_count = 0;
    results_pending = 0;
  end

  task automatic clear_calibration();
    smooth_hist = '0;
    cand_value = '0;
    cand_left = '0;
    cand_pending = 1'b0;
    peak_sum = '0;
    valley_sum = '0;
    peak_cnt = '0;
    valley_cnt = '0;
  endtask

  // Folds one accepted sample into the running profile and queues a result on run end.
  task automatic fold_sample(input logic [SAMPLE_BITS-1:0] s, input logic ps,
                             input logic re);
    logic [SAMPLE_BITS:0]   pair_sum;
    logic [SAMPLE_BITS-1:0] smoothed;
    logic [SUM_BITS-1:0]    mean_peak;
    logic [SUM_BITS-1:0]    mean_valley;
    logic [SAMPLE_BITS:0]   mid_sum;
    threshold_result_t      res;
    if (ps) begin
      smooth_hist = '0;
      cand_pending = 1'b0;
    end
    pair_sum = {1'b0, smooth_hist} + {1'b0, s};
    smoothed = pair_sum[SAMPLE_BITS:1];
    // A full tally stops both counting and summing, so the mean stays exact.
    if (cand_pending) begin
      if (cand_value > cand_left && cand_value > smoothed && peak_cnt != '1) begin
        peak_sum = peak_sum + {{COUNT_BITS{1'b0}}, cand_value};
        peak_cnt = peak_cnt + 1'b1;
      end
      if (cand_value < cand_left && cand_value < smoothed && valley_cnt != '1) begin
        valley_sum = valley_sum + {{COUNT_BITS{1'b0}}, cand_value};
        valley_cnt = valley_cnt + 1'b1;
      end
    end
    cand_left = smooth_hist;
    cand_value = smoothed;
    cand_pending = 1'b1;
    smooth_hist = smoothed;
    if (re) begin
      res.threshold = '0;
      res.status = STATUS_OK;
      res.peaks = peak_cnt;
      res.valleys = valley_cnt;
      if (peak_cnt == '0) res.status = res.status | STATUS_NO_PEAKS;
      if (valley_cnt == '0) res.status = res.status | STATUS_NO_VALLEYS;
      if (res.status == STATUS_OK) begin
        mean_peak = peak_sum / {{SAMPLE_BITS{1'b0}}, peak_cnt};
        mean_valley = valley_sum / {{SAMPLE_BITS{1'b0}}, valley_cnt};
        mid_sum = {1'b0, mean_peak[SAMPLE_BITS-1:0]} + {1'b0, mean_valley[SAMPLE_BITS-1:0]};
        res.threshold = mid_sum[SAMPLE_BITS:1];
      end
      expected_thresholds.push_back(res);
      clear_calibration();
    end
  endtask

  task automatic check_field(input string field_name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name,
               exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    threshold_result_t exp_res;
    if (!rst_n) begin
      clear_calibration();
      expected_thresholds.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_thresholds.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual threshold %0d",
                   $time, out_threshold, " status %0d peaks %0d valleys %0d",
                   out_status, out_peaks_found, out_valleys_found);
          mismatch_count++;
        end else begin
          exp_res = expected_thresholds.pop_front();
          check_field("threshold", exp_res.threshold, out_threshold);
          check_field("status", exp_res.status, out_status);
          check_field("peaks_found", exp_res.peaks, out_peaks_found);
          check_field("valleys_found", exp_res.valleys, out_valleys_found);
        end
      end
      if (in_valid && !in_stall) fold_sample(in_sample, in_pass_start, in_run_end);
    end
    results_pending <= expected_thresholds.size();
  end

endmodule

[tb/peak_valley_midpoint_threshold_top_tb.sv]
`timescale 1ns / 1ps

module peak_valley_midpoint_threshold_top_tb;
  import pvmt_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_BEATS = 930;
  localparam int DRAIN_CYCLES = 60;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_pass_start;
  logic                   in_run_end;
  logic                   out_valid;
  logic                   out_stall;
  logic [SAMPLE_BITS-1:0] out_threshold;
  logic [1:0]             out_status;
  logic [COUNT_BITS-1:0]  out_peaks_found;
  logic [COUNT_BITS-1:0]  out_valleys_found;
  int                     mismatch_count;
  int                     results_pending;

  bit                     no_idle;
  int                     beats_sent;
  int                     stall_left;
  int                     idle_cycles;

  peak_valley_midpoint_threshold_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_pass_start    (in_pass_start),
    .in_run_end       (in_run_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_threshold    (out_threshold),
    .out_status       (out_status),
    .out_peaks_found  (out_peaks_found),
    .out_valleys_found(out_valleys_found)
  );

  pvmt_threshold_checker u_threshold_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_pass_start    (in_pass_start),
    .in_run_end       (in_run_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_threshold    (out_threshold),
    .out_status       (out_status),
    .out_peaks_found  (out_peaks_found),
    .out_valleys_found(out_valleys_found),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  // The stall for the next result is drawn in advance and only counts down
  // while that result is on offer, so each result waits out its own draw.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = draw_wait();
    end else if (out_valid && !out_stall) begin
      stall_left = draw_wait();
    end else if (out_valid && stall_left != 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("peak_valley_midpoint_threshold_top regression: fail");
      $finish;
    end
  end

  // Called right after a rising edge; returns right after the edge that takes the beat.
  task automatic send_beat(input logic [SAMPLE_BITS-1:0] s, input logic ps,
                           input logic re);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_pass_start <= ps;
    in_run_end <= re;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // One calibration run: a few passes of shaped samples, with some stray flags.
  task automatic send_run();
    int passes;
    int len;
    int shape;
    logic [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0] level;
    logic ps;
    logic re;
    passes = $urandom_range(1, 4);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int p = 0; p < passes; p++) begin
      len = $urandom_range(1, 12);
      shape = $urandom_range(0, 3);
      level = SAMPLE_BITS'($urandom_range(0, 2047));
      for (int k = 0; k < len; k++) begin
        case (shape)
          0: s = SAMPLE_BITS'($urandom_range(0, 2047));
          1: s = k[0] ? SAMPLE_BITS'($urandom_range(0, 600))
                      : SAMPLE_BITS'($urandom_range(1400, 2047));
          // Small steps around a level give equal neighbors and plateaus.
          2: begin
            level = level + SAMPLE_BITS'($urandom_range(0, 4)) - SAMPLE_BITS'(2);
            s = level;
          end
          default: s = (k[0] ^ $urandom_range(0, 1)) ? {SAMPLE_BITS{1'b1}} : '0;
        endcase
        ps = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
        re = (p == passes - 1) && (k == len - 1);
        if ($urandom_range(0, 49) == 0) re = 1'b1;
        send_beat(s, ps, re);
      end
    end
  endtask

  initial begin
    int random_start;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    in_pass_start <= 1'b0;
    in_run_end <= 1'b0;
    out_stall <= 1'b0;
    no_idle = 1'b0;
    beats_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // First run without a pass start: alternating extremes give peaks and valleys.
    send_beat(11'd2047, 1'b0, 1'b0);
    send_beat(11'd0, 1'b0, 1'b0);
    send_beat(11'd2047, 1'b0, 1'b0);
    send_beat(11'd0, 1'b0, 1'b0);
    send_beat(11'd2047, 1'b0, 1'b1);
    // Flat run: neither kind found.
    send_beat(11'd0, 1'b1, 1'b0);
    send_beat(11'd0, 1'b0, 1'b0);
    send_beat(11'd0, 1'b0, 1'b1);
    // Peak only.
    send_beat(11'd2047, 1'b1, 1'b0);
    send_beat(11'd0, 1'b0, 1'b1);
    // Valley only: a plateau keeps the first rise from counting as a peak.
    send_beat(11'd2, 1'b1, 1'b0);
    send_beat(11'd1, 1'b0, 1'b0);
    send_beat(11'd0, 1'b0, 1'b0);
    send_beat(11'd2, 1'b0, 1'b1);
    // Single beat that both starts a pass and ends the run.
    send_beat(11'd1000, 1'b1, 1'b1);
    // New pass inside a run drops the pending candidate but keeps the sums.
    send_beat(11'd2047, 1'b1, 1'b0);
    send_beat(11'd0, 1'b0, 1'b0);
    send_beat(11'd2047, 1'b1, 1'b0);
    send_beat(11'd0, 1'b0, 1'b0);
    send_beat(11'd1024, 1'b0, 1'b1);

    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) send_run();

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("peak_valley_midpoint_threshold_top regression: pass");
    end else begin
      $display("peak_valley_midpoint_threshold_top regression: fail");
    end
    $finish;
  end

endmodule
